// ===== design/esr_pkg.sv =====
// Package: phase codes, register indexes and reset values for the error-stop sequencer.
`timescale 1ns / 1ps
`default_nettype none
package esr_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [DIGIT_W-1:0] RESTART_DIGIT_RST = 4'd0;
  localparam logic [DIGIT_W-1:0] RESUME_DIGIT_RST = 4'd11;
  localparam logic [COUNT_W-1:0] TIMEOUT_LIMIT_RST = 10'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESTART_DIGIT = 2'd0,
    REG_RESUME_DIGIT  = 2'd1,
    REG_TIMEOUT_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SENSE1 = 3'd1,
    PH_SENSE2 = 3'd2,
    PH_SENSE3 = 3'd3,
    PH_SENSE4 = 3'd4,
    PH_SENSE5 = 3'd5,
    PH_STOP1  = 3'd6,
    PH_STOP2  = 3'd7
  } phase_t;

endpackage
`default_nettype wire

// ===== design/error_stop_restart_sequencer.sv =====
// Top level: error-stop latch and sensed restart handshake sequencer.
// Each accepted input beat loads its result into the output register.
// Throughput: one beat per cycle; the input stalls only while a held result is stalled.
// Reset: rst (synchronous) returns the sequencer to idle, clears all latches and the
// wait count, loads restart digit 0, resume digit 11, timeout limit 600.
`timescale 1ns / 1ps
`default_nettype none
module error_stop_restart_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [esr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esr_pkg::COUNT_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [esr_pkg::DIGIT_W-1:0]    digit_time,
  input  wire logic                           lower_half,
  input  wire logic                           sense_switch,
  input  wire logic                           stop_reset,
  input  wire logic                           clock_fault,
  input  wire logic                           stop_request,
  input  wire logic                           channel_busy,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                sense_on,
  output logic                                stop_active,
  output logic                                restart_pulse,
  output logic                                restart_clear,
  output logic                                run_off,
  output logic                                timed_out
);
  import esr_pkg::*;

  logic [DIGIT_W-1:0] restart_digit;
  logic [DIGIT_W-1:0] resume_digit;
  logic [COUNT_W-1:0] timeout_limit;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] wait_count, wait_count_next;
  logic               sense_latch, sense_latch_next;
  logic               stop_latch, stop_latch_next;
  logic               restart_pulse_reg, restart_pulse_next;
  logic               restart_clear_reg, restart_clear_next;
  logic               run_off_reg, run_off_next;
  logic               tmo;

  logic               in_accept;
  logic               over;
  logic [COUNT_W-1:0] count_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      restart_digit <= RESTART_DIGIT_RST;
      resume_digit  <= RESUME_DIGIT_RST;
      timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESTART_DIGIT: restart_digit <= cfg_data[DIGIT_W-1:0];
        REG_RESUME_DIGIT:  resume_digit  <= cfg_data[DIGIT_W-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // wait check: compare before the saturating increment
  assign over      = wait_count > timeout_limit;
  assign count_inc = (wait_count == COUNT_MAX) ? wait_count : wait_count + 1'b1;

  always_comb begin
    phase_next         = phase;
    wait_count_next    = wait_count;
    sense_latch_next   = sense_latch;
    stop_latch_next    = stop_latch;
    restart_pulse_next = restart_pulse_reg;
    restart_clear_next = restart_clear_reg;
    run_off_next       = run_off_reg;
    tmo                = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (stop_reset) begin
          stop_latch_next = 1'b0;
        end else if (!stop_latch && (clock_fault || stop_request)) begin
          stop_latch_next = 1'b1;
          wait_count_next = '0;
          if (sense_switch) begin
            sense_latch_next = 1'b1;
            phase_next       = PH_SENSE1;
          end else begin
            phase_next = PH_STOP1;
          end
        end
      end
      PH_SENSE1: begin
        if (channel_busy) begin
          wait_count_next = count_inc;
          if (over) begin
            tmo        = 1'b1;
            phase_next = PH_IDLE;
          end
        end else begin
          phase_next = PH_SENSE2;
        end
      end
      PH_SENSE2: begin
        if (!lower_half && digit_time == restart_digit) begin
          restart_clear_next = 1'b1;
          run_off_next       = 1'b1;
          wait_count_next    = '0;
          phase_next         = PH_SENSE3;
        end
      end
      PH_SENSE3: begin
        run_off_next = 1'b0;
        if (channel_busy) begin
          restart_clear_next = 1'b0;
          wait_count_next    = '0;
          phase_next         = PH_SENSE4;
        end else begin
          wait_count_next = count_inc;
          if (over) begin
            tmo        = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_SENSE4: begin
        if (!channel_busy && lower_half && digit_time == resume_digit) begin
          stop_latch_next    = 1'b0;
          restart_pulse_next = 1'b1;
          phase_next         = PH_SENSE5;
        end else begin
          wait_count_next = count_inc;
          if (over) begin
            tmo        = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_SENSE5: begin
        restart_pulse_next = 1'b0;
        phase_next         = PH_IDLE;
      end
      PH_STOP1: begin
        run_off_next = 1'b1;
        phase_next   = PH_STOP2;
      end
      PH_STOP2: begin
        run_off_next = 1'b0;
        phase_next   = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      wait_count        <= '0;
      sense_latch       <= 1'b0;
      stop_latch        <= 1'b0;
      restart_pulse_reg <= 1'b0;
      restart_clear_reg <= 1'b0;
      run_off_reg       <= 1'b0;
    end else if (in_accept) begin
      phase             <= phase_next;
      wait_count        <= wait_count_next;
      sense_latch       <= sense_latch_next;
      stop_latch        <= stop_latch_next;
      restart_pulse_reg <= restart_pulse_next;
      restart_clear_reg <= restart_clear_next;
      run_off_reg       <= run_off_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sense_on      <= sense_latch_next;
      stop_active   <= stop_latch_next;
      restart_pulse <= restart_pulse_next;
      restart_clear <= restart_clear_next;
      run_off       <= run_off_next;
      timed_out     <= tmo;
    end
  end

  a_timeout_keeps_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> stop_active)
    else $error("timeout beat with stop latch clear");

  a_restart_clears_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && restart_pulse |-> !stop_active)
    else $error("restart pulse with stop latch still set");

  a_sense5_pulse: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SENSE5 |-> restart_pulse_reg)
    else $error("restart pulse register low in final sense phase");

  a_stop2_runoff: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP2 |-> run_off_reg && stop_latch)
    else $error("run-off pulse or stop latch missing in stop pulse phase");

endmodule
`default_nettype wire
